// ----- sv/pffa_pkg.sv -----
// ============================================================================
// pffa_pkg
// Shared field widths, request kinds and result status codes of the paged
// first-fit allocator.
// ============================================================================
package pffa_pkg;

  // Field widths of the request and result transactions
  localparam int unsigned KIND_W   = 1;
  localparam int unsigned SIZE_W   = 7;
  localparam int unsigned ADDR_W   = 10;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned PAGES_W  = 5;

  // Usable page size after reset
  localparam logic [SIZE_W-1:0] PAGE_BYTES_RST = 7'd8;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b0;
  localparam logic [KIND_W-1:0] KIND_FREE  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_PAGE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_SIZE  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

endpackage

// ----- sv/paged_first_fit_allocator_unit.sv -----
// ============================================================================
// paged_first_fit_allocator_unit
// Byte-granular first-fit allocator over pages opened on demand. Allocate
// scans the open pages for the lowest free run; free releases a block by its
// start address.
// ============================================================================
//
// Channel   Direction  Handshake                 Payload
// --------  ---------  ------------------------  ------------------------------
// request   in         in_valid_i / in_ready_o   kind_i, request_size_i,
//                                                free_address_i
// result    out        out_valid_o / out_ready_i status_o, granted_address_o,
//                                                pages_in_use_o
// config    in         cfg_valid_i / cfg_ready_o cfg_page_bytes_i
//
// An allocate reads the open pages in turn: the page-word read is pipelined
// against the first-fit check, one page per cycle. A free finds its page
// index by stepping the shared base-address adder one page per cycle, then
// checks the word of that page. A bad size goes straight to the result. No
// clearing pass is needed after reset: pages beyond the open-page count are
// never used. The request side is held off while a transaction is in work or
// its result waits for the output register; a finished result waits in the
// output register while the next request is taken.
// ============================================================================
module paged_first_fit_allocator_unit #(
  parameter int unsigned MAX_PAGES      = 16,
  parameter int unsigned MAX_PAGE_BYTES = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pffa_pkg::SIZE_W-1:0]   cfg_page_bytes_i,
  // request
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [pffa_pkg::KIND_W-1:0]   kind_i,
  input  logic [pffa_pkg::SIZE_W-1:0]   request_size_i,
  input  logic [pffa_pkg::ADDR_W-1:0]   free_address_i,
  // result
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [pffa_pkg::STATUS_W-1:0] status_o,
  output logic [pffa_pkg::ADDR_W-1:0]   granted_address_o,
  output logic [pffa_pkg::PAGES_W-1:0]  pages_in_use_o
);

  localparam int unsigned PW    = $clog2(MAX_PAGES + 1);
  localparam int unsigned PIW   = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int unsigned OW    = (MAX_PAGE_BYTES > 1) ? $clog2(MAX_PAGE_BYTES) : 1;
  localparam int unsigned DEPTH = MAX_PAGES * MAX_PAGE_BYTES;
  localparam int unsigned LW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned BW    = $clog2(DEPTH + 1);
  localparam int unsigned XW    = (BW > pffa_pkg::ADDR_W) ? BW : pffa_pkg::ADDR_W;
  localparam int unsigned QW    = (PW > pffa_pkg::PAGES_W) ? PW : pffa_pkg::PAGES_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_LOCATE = 3'd2;
  localparam logic [2:0] S_FCHK   = 3'd3;
  localparam logic [2:0] S_RESP   = 3'd4;

  logic [2:0]                     state_q, state_d;
  logic [pffa_pkg::SIZE_W-1:0]    page_bytes_q;
  logic [pffa_pkg::SIZE_W-1:0]    n_q, n_d;
  logic [pffa_pkg::SIZE_W-1:0]    lim_q, lim_d;
  logic [PW-1:0]                  page_q, page_d;
  logic [BW-1:0]                  base_q, base_d;
  logic                           ev_v_q, ev_v_d;
  logic [PIW-1:0]                 ev_page_q, ev_page_d;
  logic [BW-1:0]                  ev_base_q, ev_base_d;
  logic [PW-1:0]                  open_q, open_d;
  logic [pffa_pkg::ADDR_W-1:0]    faddr_q, faddr_d;
  logic [OW-1:0]                  off_q, off_d;
  logic [pffa_pkg::STATUS_W-1:0]  res_status_q, res_status_d;
  logic [pffa_pkg::ADDR_W-1:0]    res_addr_q, res_addr_d;
  logic                           out_valid_q;
  logic [pffa_pkg::STATUS_W-1:0]  out_status_q;
  logic [pffa_pkg::ADDR_W-1:0]    out_addr_q;
  logic [pffa_pkg::PAGES_W-1:0]   out_pages_q;

  logic [pffa_pkg::SIZE_W-1:0]    len_mem [DEPTH];
  logic [pffa_pkg::SIZE_W-1:0]    len_rd_q;
  logic                           len_we;
  logic [LW-1:0]                  len_widx;
  logic [pffa_pkg::SIZE_W-1:0]    len_eff;

  logic                           wr_en;
  logic [PIW-1:0]                 wr_page;
  logic [MAX_PAGE_BYTES-1:0]      wr_busy, wr_start;
  logic [MAX_PAGE_BYTES-1:0]      rd_busy, rd_start;

  logic                           fit_hit;
  logic [OW-1:0]                  fit_off;
  logic [OW-1:0]                  m_start;
  logic [pffa_pkg::SIZE_W-1:0]    m_len;
  logic [MAX_PAGE_BYTES-1:0]      mask, pick;

  logic [BW-1:0]                  next_base;
  logic [XW-1:0]                  base_x, faddr_x, grant_x;
  logic [QW-1:0]                  pages_x;
  logic [pffa_pkg::SIZE_W-1:0]    eff_limit;

  // Page maps
  pffa_page_store #(
    .MAX_PAGES      (MAX_PAGES),
    .MAX_PAGE_BYTES (MAX_PAGE_BYTES)
  ) u_store (
    .clk_i      (clk_i),
    .wr_en_i    (wr_en),
    .wr_page_i  (wr_page),
    .wr_busy_i  (wr_busy),
    .wr_start_i (wr_start),
    .rd_page_i  (PIW'(page_q)),
    .rd_busy_o  (rd_busy),
    .rd_start_o (rd_start)
  );

  // First-fit check on the page word read last cycle
  pffa_fit_scan #(
    .MAX_PAGE_BYTES (MAX_PAGE_BYTES)
  ) u_fit (
    .busy_i   (rd_busy),
    .size_i   (n_q),
    .limit_i  (lim_q),
    .hit_o    (fit_hit),
    .offset_o (fit_off)
  );

  // Block lengths, indexed by start address
  always_ff @(posedge clk_i) begin
    if (len_we) begin
      len_mem[len_widx] <= n_q;
    end
    len_rd_q <= len_mem[LW'(faddr_q)];
  end

  // Shared base-address adder and address views
  assign next_base = base_q + BW'(MAX_PAGE_BYTES);
  assign base_x    = XW'(base_q);
  assign faddr_x   = XW'(faddr_q);
  assign grant_x   = XW'(ev_base_q) + XW'(fit_off);
  assign pages_x   = QW'(open_q);
  assign len_eff   = (len_rd_q == '0) ? pffa_pkg::SIZE_W'(1) : len_rd_q;

  // Clamp the configured page size into the usable range
  always_comb begin
    if (page_bytes_q == '0) begin
      eff_limit = pffa_pkg::SIZE_W'(1);
    end else if (page_bytes_q > pffa_pkg::SIZE_W'(MAX_PAGE_BYTES)) begin
      eff_limit = pffa_pkg::SIZE_W'(MAX_PAGE_BYTES);
    end else begin
      eff_limit = page_bytes_q;
    end
  end

  // Byte-range mask and start bit, shared by allocate and free
  always_comb begin
    for (int i = 0; i < MAX_PAGE_BYTES; i++) begin
      mask[i] = (8'(i) >= 8'(m_start)) && (8'(i) < (8'(m_start) + 8'(m_len)));
      pick[i] = (8'(i) == 8'(m_start));
    end
  end

  // Sequencer
  always_comb begin
    state_d      = state_q;
    n_d          = n_q;
    lim_d        = lim_q;
    page_d       = page_q;
    base_d       = base_q;
    ev_v_d       = ev_v_q;
    ev_page_d    = ev_page_q;
    ev_base_d    = ev_base_q;
    open_d       = open_q;
    faddr_d      = faddr_q;
    off_d        = off_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    m_start      = fit_off;
    m_len        = n_q;
    wr_en        = 1'b0;
    wr_page      = ev_page_q;
    wr_busy      = rd_busy | mask;
    wr_start     = rd_start | pick;
    len_we       = 1'b0;
    len_widx     = LW'(grant_x);

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          page_d = '0;
          base_d = '0;
          ev_v_d = 1'b0;
          if (kind_i == pffa_pkg::KIND_FREE) begin
            faddr_d = free_address_i;
            state_d = S_LOCATE;
          end else if ((request_size_i == '0) || (request_size_i > eff_limit)) begin
            res_status_d = pffa_pkg::ST_BAD_SIZE;
            res_addr_d   = '0;
            state_d      = S_RESP;
          end else begin
            n_d     = request_size_i;
            lim_d   = eff_limit;
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (ev_v_q && fit_hit) begin
          // Claim the run in the page just checked
          wr_en        = 1'b1;
          len_we       = 1'b1;
          res_status_d = pffa_pkg::ST_OK;
          res_addr_d   = grant_x[pffa_pkg::ADDR_W-1:0];
          state_d      = S_RESP;
        end else if (page_q < open_q) begin
          // Issue the next page read
          ev_v_d    = 1'b1;
          ev_page_d = PIW'(page_q);
          ev_base_d = base_q;
          page_d    = page_q + PW'(1);
          base_d    = next_base;
        end else begin
          ev_v_d  = 1'b0;
          m_start = '0;
          if (open_q == PW'(MAX_PAGES)) begin
            res_status_d = pffa_pkg::ST_NO_PAGE;
            res_addr_d   = '0;
          end else begin
            // Open a fresh page and place the block at its start
            wr_en        = 1'b1;
            wr_page      = PIW'(open_q);
            wr_busy      = mask;
            wr_start     = pick;
            len_we       = 1'b1;
            len_widx     = LW'(base_q);
            open_d       = open_q + PW'(1);
            res_status_d = pffa_pkg::ST_OK;
            res_addr_d   = base_x[pffa_pkg::ADDR_W-1:0];
          end
          state_d = S_RESP;
        end
      end

      S_LOCATE: begin
        if (page_q == open_q) begin
          res_status_d = pffa_pkg::ST_NOT_FOUND;
          res_addr_d   = '0;
          state_d      = S_RESP;
        end else if (faddr_x < XW'(next_base)) begin
          // Address lies in this page: its word is read now
          off_d     = OW'(faddr_x - base_x);
          ev_page_d = PIW'(page_q);
          state_d   = S_FCHK;
        end else begin
          page_d = page_q + PW'(1);
          base_d = next_base;
        end
      end

      S_FCHK: begin
        m_start = off_q;
        m_len   = len_eff;
        if (!rd_start[off_q]) begin
          res_status_d = pffa_pkg::ST_NOT_FOUND;
        end else begin
          // Release the block's bytes and drop its start mark
          wr_en        = 1'b1;
          wr_busy      = rd_busy & ~mask;
          wr_start     = rd_start & ~pick;
          res_status_d = pffa_pkg::ST_OK;
        end
        res_addr_d = '0;
        state_d    = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      open_q       <= '0;
      ev_v_q       <= 1'b0;
      page_bytes_q <= pffa_pkg::PAGE_BYTES_RST;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      open_q  <= open_d;
      ev_v_q  <= ev_v_d;
      if (cfg_valid_i) begin
        page_bytes_q <= cfg_page_bytes_i;
      end
      if ((state_q == S_RESP) && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working and result payload registers
  always_ff @(posedge clk_i) begin
    n_q          <= n_d;
    lim_q        <= lim_d;
    page_q       <= page_d;
    base_q       <= base_d;
    ev_page_q    <= ev_page_d;
    ev_base_q    <= ev_base_d;
    faddr_q      <= faddr_d;
    off_q        <= off_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    if ((state_q == S_RESP) && (!out_valid_q || out_ready_i)) begin
      out_status_q <= res_status_q;
      out_addr_q   <= res_addr_q;
      out_pages_q  <= pages_x[pffa_pkg::PAGES_W-1:0];
    end
  end

  assign cfg_ready_o       = 1'b1;
  assign in_ready_o        = (state_q == S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign granted_address_o = out_addr_q;
  assign pages_in_use_o    = out_pages_q;

endmodule

// ----- sv/pffa_page_store.sv -----
// ============================================================================
// pffa_page_store
// Per-page occupancy and allocation-start words, one word per page, one write
// port and one read port with registered read data.
// ============================================================================
module pffa_page_store #(
  parameter int unsigned MAX_PAGES      = 16,
  parameter int unsigned MAX_PAGE_BYTES = 64,
  localparam int unsigned PIW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1
) (
  input  logic                      clk_i,
  input  logic                      wr_en_i,
  input  logic [PIW-1:0]            wr_page_i,
  input  logic [MAX_PAGE_BYTES-1:0] wr_busy_i,
  input  logic [MAX_PAGE_BYTES-1:0] wr_start_i,
  input  logic [PIW-1:0]            rd_page_i,
  output logic [MAX_PAGE_BYTES-1:0] rd_busy_o,
  output logic [MAX_PAGE_BYTES-1:0] rd_start_o
);

  logic [MAX_PAGE_BYTES-1:0] busy_mem  [MAX_PAGES];
  logic [MAX_PAGE_BYTES-1:0] start_mem [MAX_PAGES];

  // Write the selected page, read a page into the output registers
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      busy_mem[wr_page_i]  <= wr_busy_i;
      start_mem[wr_page_i] <= wr_start_i;
    end
    rd_busy_o  <= busy_mem[rd_page_i];
    rd_start_o <= start_mem[rd_page_i];
  end

endmodule

// ----- sv/pffa_fit_scan.sv -----
// ============================================================================
// pffa_fit_scan
// First-fit search within one page word: finds the lowest offset that opens
// a run of size free bytes ending inside the usable part of the page.
// ============================================================================
module pffa_fit_scan #(
  parameter int unsigned MAX_PAGE_BYTES = 64,
  localparam int unsigned OW = (MAX_PAGE_BYTES > 1) ? $clog2(MAX_PAGE_BYTES) : 1
) (
  input  logic [MAX_PAGE_BYTES-1:0]   busy_i,
  input  logic [pffa_pkg::SIZE_W-1:0] size_i,
  input  logic [pffa_pkg::SIZE_W-1:0] limit_i,
  output logic                        hit_o,
  output logic [OW-1:0]               offset_o
);

  logic [MAX_PAGE_BYTES-1:0] fit;

  // Mark every start offset whose window is free and inside the limit
  always_comb begin
    for (int j = 0; j < MAX_PAGE_BYTES; j++) begin
      fit[j] = ((8'(j) + 8'(size_i)) <= 8'(limit_i));
      for (int i = 0; i < MAX_PAGE_BYTES; i++) begin
        if ((i >= j) && (8'(i) < (8'(j) + 8'(size_i))) && busy_i[i]) begin
          fit[j] = 1'b0;
        end
      end
    end
  end

  // Pick the lowest fitting offset
  always_comb begin
    offset_o = '0;
    for (int j = MAX_PAGE_BYTES - 1; j >= 0; j--) begin
      if (fit[j]) begin
        offset_o = OW'(j);
      end
    end
  end

  assign hit_o = |fit;

endmodule
